// File: hdl/cett_pkg.sv
// shared constants and control types for the coarse event timer table
package cett_pkg;

  localparam int unsigned SLOTS_DEF = 8;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] KIND_POLL = 2'd0;
  localparam logic [1:0] KIND_ONESHOT = 2'd1;
  localparam logic [1:0] KIND_PERIODIC = 2'd2;

  localparam logic [2:0] RK_ARMED = 3'd0;
  localparam logic [2:0] RK_FULL = 3'd1;
  localparam logic [2:0] RK_ONESHOT = 3'd2;
  localparam logic [2:0] RK_PERIODIC = 3'd3;
  localparam logic [2:0] RK_NONE = 3'd4;

  typedef struct packed {
    logic capture;
    logic arm;
    logic fire_take;
    logic push;
    logic flush;
    logic pend_valid;
    logic phase;
  } cett_cmd_t;

  typedef struct packed {
    logic fire;
    logic out_free;
  } cett_status_t;

endpackage

// File: hdl/cett_ctrl.sv
// controller: request decode, slot scan sequencing and result ordering
module cett_ctrl
  import cett_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF,
  parameter int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   kind_i,
  input  cett_status_t status_i,
  output cett_cmd_t    cmd_o,
  output logic [IDX_W-1:0] idx_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ARM = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pend_q, pend_d;
  logic             last_entry;
  logic             hit_limit;

  assign last_entry = phase_q && (idx_q == IDX_W'(SLOTS - 1));
  assign hit_limit = (cnt_q + CNT_W'(1)) == CNT_W'(MAX_RESULTS);
  assign idx_o = idx_q;

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    phase_d = phase_q;
    cnt_d = cnt_q;
    pend_d = pend_q;
    in_ready_o = 1'b0;
    cmd_o = '0;
    cmd_o.phase = phase_q;
    cmd_o.pend_valid = pend_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (kind_i == KIND_POLL) begin
            state_d = ST_SCAN;
            idx_d = '0;
            phase_d = 1'b0;
            cnt_d = '0;
            pend_d = 1'b0;
          end else if (kind_i == KIND_ONESHOT || kind_i == KIND_PERIODIC) begin
            state_d = ST_ARM;
          end
        end
      end
      ST_ARM: begin
        if (status_i.out_free) begin
          cmd_o.arm = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!(status_i.fire && pend_q && !status_i.out_free)) begin
          if (status_i.fire) begin
            cmd_o.fire_take = 1'b1;
            cmd_o.push = pend_q;
            pend_d = 1'b1;
            cnt_d = cnt_q + CNT_W'(1);
          end
          if ((status_i.fire && hit_limit) || last_entry) begin
            state_d = ST_FLUSH;
          end else begin
            phase_d = !phase_q;
            if (phase_q) begin
              idx_d = idx_q + IDX_W'(1);
            end
          end
        end
      end
      ST_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q <= '0;
      phase_q <= 1'b0;
      cnt_q <= '0;
      pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      phase_q <= phase_d;
      cnt_q <= cnt_d;
      pend_q <= pend_d;
    end
  end

endmodule

// File: hdl/cett_dp.sv
// datapath: slot tables, expiry check, pending result and output register
module cett_dp
  import cett_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF,
  parameter int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cett_cmd_t        cmd_i,
  input  logic [IDX_W-1:0] idx_i,
  output cett_status_t     status_o,
  input  logic [1:0]       kind_i,
  input  logic [31:0]      now_us_i,
  input  logic [31:0]      interval_us_i,
  input  logic [7:0]       handle_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       result_kind_o,
  output logic [2:0]       slot_o,
  output logic [7:0]       event_handle_o,
  output logic [31:0]      measured_period_us_o,
  output logic             last_o
);

  logic [1:0]  kind_q;
  logic [31:0] now_q;
  logic [31:0] ival_q;
  logic [7:0]  handle_q;

  logic [SLOTS-1:0] os_armed_q, os_armed_d;
  logic [SLOTS-1:0] pe_armed_q, pe_armed_d;
  logic [31:0] os_start_q [SLOTS];
  logic [31:0] os_delay_q [SLOTS];
  logic [7:0]  os_handle_q [SLOTS];
  logic [31:0] pe_start_q [SLOTS];
  logic [31:0] pe_period_q [SLOTS];
  logic [7:0]  pe_handle_q [SLOTS];

  logic [2:0]  pend_kind_q;
  logic [2:0]  pend_slot_q;
  logic [7:0]  pend_handle_q;
  logic [31:0] pend_period_q;

  logic        out_valid_q;
  logic [2:0]  out_kind_q;
  logic [2:0]  out_slot_q;
  logic [7:0]  out_handle_q;
  logic [31:0] out_period_q;
  logic        out_last_q;

  logic             sel_armed;
  logic [31:0]      sel_start;
  logic [31:0]      sel_ival;
  logic [7:0]       sel_handle;
  logic [31:0]      elapsed;
  logic             out_free;
  logic             out_load;
  logic             is_periodic;
  logic [SLOTS-1:0] free_vec;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // entry under test
  assign sel_armed = cmd_i.phase ? pe_armed_q[idx_i] : os_armed_q[idx_i];
  assign sel_start = cmd_i.phase ? pe_start_q[idx_i] : os_start_q[idx_i];
  assign sel_ival = cmd_i.phase ? pe_period_q[idx_i] : os_delay_q[idx_i];
  assign sel_handle = cmd_i.phase ? pe_handle_q[idx_i] : os_handle_q[idx_i];
  assign elapsed = now_q - sel_start;

  assign out_free = !out_valid_q || out_ready_i;
  assign status_o.fire = sel_armed && (elapsed > sel_ival);
  assign status_o.out_free = out_free;
  assign out_load = cmd_i.arm || cmd_i.push || cmd_i.flush;

  // first free slot of the addressed table
  assign is_periodic = (kind_q == KIND_PERIODIC);
  assign free_vec = is_periodic ? ~pe_armed_q : ~os_armed_q;

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_found = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    os_armed_d = os_armed_q;
    pe_armed_d = pe_armed_q;
    if (cmd_i.arm && free_found) begin
      if (is_periodic) begin
        pe_armed_d[free_idx] = 1'b1;
      end else begin
        os_armed_d[free_idx] = 1'b1;
      end
    end
    if (cmd_i.fire_take && !cmd_i.phase) begin
      os_armed_d[idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      os_armed_q <= '0;
      pe_armed_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      os_armed_q <= os_armed_d;
      pe_armed_q <= pe_armed_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      now_q <= now_us_i;
      ival_q <= interval_us_i;
      handle_q <= handle_i;
    end
  end

  // table writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.arm && free_found) begin
      if (is_periodic) begin
        pe_start_q[free_idx] <= now_q;
        pe_period_q[free_idx] <= ival_q;
        pe_handle_q[free_idx] <= handle_q;
      end else begin
        os_start_q[free_idx] <= now_q;
        os_delay_q[free_idx] <= ival_q;
        os_handle_q[free_idx] <= handle_q;
      end
    end
    if (cmd_i.fire_take && cmd_i.phase) begin
      pe_start_q[idx_i] <= now_q;
    end
  end

  // pending fire, held until the next fire or the end of the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.fire_take) begin
      pend_kind_q <= cmd_i.phase ? RK_PERIODIC : RK_ONESHOT;
      pend_slot_q <= 3'(idx_i);
      pend_handle_q <= sel_handle;
      pend_period_q <= cmd_i.phase ? elapsed : 32'd0;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.arm) begin
      out_kind_q <= free_found ? RK_ARMED : RK_FULL;
      out_slot_q <= free_found ? 3'(free_idx) : 3'd0;
      out_handle_q <= handle_q;
      out_period_q <= 32'd0;
      out_last_q <= 1'b1;
    end else if (cmd_i.push || (cmd_i.flush && cmd_i.pend_valid)) begin
      out_kind_q <= pend_kind_q;
      out_slot_q <= pend_slot_q;
      out_handle_q <= pend_handle_q;
      out_period_q <= pend_period_q;
      out_last_q <= cmd_i.flush;
    end else if (cmd_i.flush) begin
      out_kind_q <= RK_NONE;
      out_slot_q <= 3'd0;
      out_handle_q <= 8'd0;
      out_period_q <= 32'd0;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign slot_o = out_slot_q;
  assign event_handle_o = out_handle_q;
  assign measured_period_us_o = out_period_q;
  assign last_o = out_last_q;

endmodule

// File: hdl/coarse_event_timer_table_unit.sv
// top level of the coarse event timer table
//
// Requests enter on a valid/ready channel: kind 0 polls with the current
// microsecond time, kind 1 and kind 2 arm a one-shot or periodic event in
// the first free slot of its table, kind 3 is dropped without a result.
// Results leave on a valid/ready channel; last_o marks the final result of
// a request. An arm loads its one result, armed or table full, into the
// output register from the ARM state once that register is free, and the
// input is ready again as the result is loaded. A poll checks one table
// entry per cycle, unless held by a stalled receiver as below, through a
// single subtract-and-compare, one-shot before periodic for each slot; it
// yields up to 16 results (one "nothing fired" result if none expire). A
// new request is taken once the previous one has queued its final result
// in the output register.
// Reset clears the armed bits of both tables and the output valid flag; the
// slot contents are written on arm. When the receiver stalls, the result
// stays in the output register; the scan keeps one more fire pending and
// halts when a further fire finds the output register still full.
module coarse_event_timer_table_unit
  import cett_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] now_us_i,
  input  logic [31:0] interval_us_i,
  input  logic [7:0]  handle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [2:0]  slot_o,
  output logic [7:0]  event_handle_o,
  output logic [31:0] measured_period_us_o,
  output logic        last_o
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  cett_cmd_t        cmd;
  cett_status_t     status;
  logic [IDX_W-1:0] idx;

  cett_ctrl #(
    .SLOTS(SLOTS),
    .IDX_W(IDX_W)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .kind_i    (kind_i),
    .status_i  (status),
    .cmd_o     (cmd),
    .idx_o     (idx)
  );

  cett_dp #(
    .SLOTS(SLOTS),
    .IDX_W(IDX_W)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .idx_i               (idx),
    .status_o            (status),
    .kind_i              (kind_i),
    .now_us_i            (now_us_i),
    .interval_us_i       (interval_us_i),
    .handle_i            (handle_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .result_kind_o       (result_kind_o),
    .slot_o              (slot_o),
    .event_handle_o      (event_handle_o),
    .measured_period_us_o(measured_period_us_o),
    .last_o              (last_o)
  );

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.arm || cmd.push || cmd.flush) |-> status.out_free)
    else $error("output register loaded while holding an untaken result");

  a_push_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> (cmd.fire_take && cmd.pend_valid))
    else $error("pending result pushed without a new fire");

  a_poll_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o &&
     (kind_i == KIND_POLL || kind_i == KIND_ONESHOT || kind_i == KIND_PERIODIC))
    |=> !in_ready_o)
    else $error("new request taken before the previous one finished");

  a_period_only_periodic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o != RK_PERIODIC) |-> (measured_period_us_o == 32'd0))
    else $error("measured period on a non-periodic result");

endmodule

// File: test/coarse_event_timer_table_unit_test.sv
// testbench for the coarse event timer table: directed corners, random traffic, back-pressure
`timescale 1ns / 1ps

module coarse_event_timer_table_unit_test;
  import cett_pkg::*;

  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PRINT_CAP = 20;

  typedef struct packed {
    logic [2:0]  rk;
    logic [2:0]  slot;
    logic [7:0]  handle;
    logic [31:0] period;
    logic        last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = KIND_POLL;
  logic [31:0] now_us = '0;
  logic [31:0] interval_us = '0;
  logic [7:0]  handle = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  result_kind;
  logic [2:0]  slot;
  logic [7:0]  event_handle;
  logic [31:0] measured_period_us;
  logic        last;

  // predictor copy of the two tables
  logic        os_armed [SLOTS_DEF];
  logic [31:0] os_start [SLOTS_DEF];
  logic [31:0] os_delay [SLOTS_DEF];
  logic [7:0]  os_handle [SLOTS_DEF];
  logic        per_armed [SLOTS_DEF];
  logic [31:0] per_start [SLOTS_DEF];
  logic [31:0] per_period [SLOTS_DEF];
  logic [7:0]  per_handle [SLOTS_DEF];

  timer_result_t pending_results[$];

  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] cur_time;

  coarse_event_timer_table_unit dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .kind_i              (kind),
    .now_us_i            (now_us),
    .interval_us_i       (interval_us),
    .handle_i            (handle),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .result_kind_o       (result_kind),
    .slot_o              (slot),
    .event_handle_o      (event_handle),
    .measured_period_us_o(measured_period_us),
    .last_o              (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < PRINT_CAP) begin
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    end
    error_count++;
  endtask

  function automatic void predict_timer_table(logic [1:0] k, logic [31:0] now,
                                              logic [31:0] ival, logic [7:0] h);
    timer_result_t batch[$];
    timer_result_t r;
    int free_idx;
    logic [31:0] elapsed;
    free_idx = -1;
    if (k == KIND_ONESHOT || k == KIND_PERIODIC) begin
      for (int i = SLOTS_DEF - 1; i >= 0; i--) begin
        if (k == KIND_ONESHOT ? !os_armed[i] : !per_armed[i]) free_idx = i;
      end
      r = '{rk: RK_FULL, slot: 3'd0, handle: h, period: 32'd0, last: 1'b1};
      if (free_idx >= 0) begin
        r.rk = RK_ARMED;
        r.slot = free_idx[2:0];
        if (k == KIND_ONESHOT) begin
          os_armed[free_idx] = 1'b1;
          os_start[free_idx] = now;
          os_delay[free_idx] = ival;
          os_handle[free_idx] = h;
        end else begin
          per_armed[free_idx] = 1'b1;
          per_start[free_idx] = now;
          per_period[free_idx] = ival;
          per_handle[free_idx] = h;
        end
      end
      pending_results.push_back(r);
    end else if (k == KIND_POLL) begin
      for (int i = 0; i < SLOTS_DEF && batch.size() < MAX_RESULTS; i++) begin
        if (os_armed[i] && (now - os_start[i]) > os_delay[i]) begin
          batch.push_back('{rk: RK_ONESHOT, slot: i[2:0], handle: os_handle[i],
                            period: 32'd0, last: 1'b0});
          os_armed[i] = 1'b0;
        end
        if (batch.size() >= MAX_RESULTS) break;
        elapsed = now - per_start[i];
        if (per_armed[i] && elapsed > per_period[i]) begin
          per_start[i] = now;
          batch.push_back('{rk: RK_PERIODIC, slot: i[2:0], handle: per_handle[i],
                            period: elapsed, last: 1'b0});
        end
      end
      if (batch.size() == 0) begin
        batch.push_back('{rk: RK_NONE, slot: 3'd0, handle: 8'd0, period: 32'd0, last: 1'b0});
      end
      batch[batch.size() - 1].last = 1'b1;
      foreach (batch[j]) pending_results.push_back(batch[j]);
    end
  endfunction

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_request(logic [1:0] k, logic [31:0] now, logic [31:0] ival,
                              logic [7:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    now_us <= now;
    interval_us <= ival;
    handle <= h;
    do @(posedge clk); while (!in_ready);
    predict_timer_table(k, now, ival, h);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned sent;
    int unsigned pick;
    logic [1:0] k;
    logic [31:0] now;
    logic [31:0] ival;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      k = (pick < 42) ? KIND_POLL : (pick < 70) ? KIND_ONESHOT :
          (pick < 95) ? KIND_PERIODIC : KIND_RESERVED;
      if (k == KIND_POLL) begin
        cur_time += ($urandom_range(99) < 5) ? $urandom() : $urandom_range(0, 1200);
      end else begin
        cur_time += $urandom_range(0, 50);
      end
      now = ($urandom_range(99) < 4) ? $urandom() : cur_time;
      pick = $urandom_range(99);
      ival = (pick < 5) ? 32'd0 : (pick < 10) ? $urandom() : $urandom_range(1, 3000);
      send_request(k, now, ival, $urandom_range(0, 255));
      if (k != KIND_RESERVED) sent++;
    end
  endtask

  task automatic test_directed_corners();
    logic [31:0] t0;
    logic [31:0] os_ival [SLOTS_DEF];
    logic [31:0] per_ival [SLOTS_DEF];
    t0 = 32'h8000_0000;
    os_ival = '{32'd0, 32'd1, 32'd7, 32'd100, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'd5, 32'd9};
    per_ival = '{32'd0, 32'hFFFF_FFFE, 32'd3, 32'd1000, 32'h0001_0000, 32'd2, 32'd1, 32'd64};
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    // empty poll and a dropped kind
    send_request(KIND_POLL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_request(KIND_RESERVED, 32'h1234_5678, 32'hFFFF_FFFF, 8'hFF);
    // handle zero, zero interval, wrap of the time base
    send_request(KIND_ONESHOT, 32'hFFFF_FFFF, 32'd0, 8'h00);
    send_request(KIND_POLL, 32'hFFFF_FFFF, 32'd0, 8'h00);
    send_request(KIND_POLL, 32'd0, 32'd0, 8'h00);
    // fill both tables, overflow each, then fire all sixteen at once
    for (int i = 0; i < SLOTS_DEF; i++) begin
      send_request(KIND_ONESHOT, t0, os_ival[i], (i == 7) ? 8'hFF : 8'(8'h10 + i));
    end
    send_request(KIND_ONESHOT, t0, 32'd1, 8'hAA);
    for (int i = 0; i < SLOTS_DEF; i++) begin
      send_request(KIND_PERIODIC, t0, per_ival[i], 8'(8'h80 + i));
    end
    send_request(KIND_PERIODIC, t0, 32'd1, 8'h55);
    send_request(KIND_POLL, t0 - 32'd1, 32'd0, 8'h00);
    cur_time = t0 - 32'd1;
  endtask

  task automatic test_random_no_idle();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    run_random(100);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 78;
    recv_stall_pct <= 0;
    run_random(100);
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct = 0;
    recv_stall_pct <= 78;
    run_random(100);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 35;
    recv_stall_pct <= 35;
    run_random(100);
  endtask

  task automatic test_backpressure_fill();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_req <= ~hold_req;
    run_random(60);
  endtask

  // result checker and receiver ready
  always @(posedge clk) begin
    timer_result_t want;
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result kind", 32'(result_kind), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (result_kind !== want.rk) report_mismatch("result_kind", 32'(result_kind), 32'(want.rk));
        if (slot !== want.slot) report_mismatch("slot", 32'(slot), 32'(want.slot));
        if (event_handle !== want.handle) begin
          report_mismatch("event_handle", 32'(event_handle), 32'(want.handle));
        end
        if (measured_period_us !== want.period) begin
          report_mismatch("measured_period_us", measured_period_us, want.period);
        end
        if (last !== want.last) report_mismatch("last", 32'(last), 32'(want.last));
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS_DEF; i++) begin
      os_armed[i] = 1'b0;
      per_armed[i] = 1'b0;
    end
    cur_time = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_backpressure_fill();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("results left over", pending_results.size(), 32'd0);
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
